FILE: src/prc_pkg.sv
// Package for the point region classifier: item and result types, the
// controller/datapath command and status types, and the per-kind microcode.
// No dependencies.
`default_nettype none

package prc_pkg;

  localparam int NUM_REGIONS = 8;
  localparam int REG_W       = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int LIMBS       = 7;            // 32-bit limbs of a wide word
  localparam int WIDE        = 32 * LIMBS;   // exact for every kind's terms
  localparam int LIMB_W      = 3;
  localparam int PC_W        = 6;
  localparam int WHICH_W     = 4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [2:0] WSEL_KIND = 3'd0;
  localparam logic [2:0] WSEL_NEN  = 3'd1;
  localparam logic [2:0] WSEL_EEN  = 3'd2;
  localparam logic [2:0] WSEL_A    = 3'd3;
  localparam logic [2:0] WSEL_B    = 3'd4;
  localparam logic [2:0] WSEL_C    = 3'd5;
  localparam logic [2:0] WSEL_D    = 3'd6;

  localparam logic [3:0] KIND_SLAB   = 4'd0;
  localparam logic [3:0] KIND_SPHERE = 4'd1;
  localparam logic [3:0] KIND_CYL    = 4'd2;
  localparam logic [3:0] KIND_CYL_H  = 4'd3;
  localparam logic [3:0] KIND_CYL_V  = 4'd4;
  localparam logic [3:0] KIND_UPPER  = 4'd5;
  localparam logic [3:0] KIND_LOWER  = 4'd6;
  localparam logic [3:0] KIND_RIGHT  = 4'd7;
  localparam logic [3:0] KIND_LEFT   = 4'd8;
  localparam logic [3:0] KIND_FRONT  = 4'd9;
  localparam logic [3:0] KIND_BACK   = 4'd10;
  localparam logic [3:0] KIND_LAST   = KIND_BACK;

  typedef struct packed {
    logic               func;
    logic [2:0]         region_index;
    logic [2:0]         word_select;
    logic signed [31:0] word_value;
    logic               point_class;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } prc_req_t;

  typedef struct packed {
    logic [WHICH_W-1:0] which_region;
    logic               bad_kind;
  } prc_rsp_t;

  typedef enum logic [2:0] {OP_END, OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_SHL} op_t;
  typedef enum logic [3:0] {
    SRC_X, SRC_Y, SRC_Z, SRC_A, SRC_B, SRC_C, SRC_D, SRC_E, SRC_ONE
  } src_t;
  typedef enum logic [1:0] {SH_2, SH_16, SH_32} sh_t;
  typedef logic [2:0] rsel_t;

  localparam rsel_t R0 = 3'd0;
  localparam rsel_t R1 = 3'd1;
  localparam rsel_t R2 = 3'd2;
  localparam rsel_t R3 = 3'd3;
  localparam rsel_t R4 = 3'd4;
  localparam rsel_t R5 = 3'd5;
  localparam rsel_t R7 = 3'd7;   // result of every program

  typedef struct packed {
    op_t   op;
    rsel_t dst;
    rsel_t s1;
    rsel_t s2;
    src_t  src;
    sh_t   sh;
  } instr_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LATCH, DP_WRITE, DP_READ, DP_LOAD, DP_ADD, DP_SUB, DP_SHL,
    DP_MABS, DP_MPP, DP_MACC, DP_MFIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [REG_W-1:0]  region;
    rsel_t             dst;
    rsel_t             s1;
    rsel_t             s2;
    src_t              src;
    sh_t               sh;
    logic [LIMB_W-1:0] li;
    logic [LIMB_W-1:0] lj;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [3:0]        kind;
    logic              t_neg;
    logic              t_zero;
    logic              a_neg;
    logic              a_zero;
    logic              b_neg;
    logic              b_zero;
    logic              c_neg;
    logic              c_zero;
    logic [LIMB_W-1:0] na_last;
    logic [LIMB_W-1:0] nb_last;
  } status_t;

  function automatic instr_t i_end();
    instr_t r;
    r = '{op: OP_END, dst: R7, s1: R7, s2: R7, src: SRC_ONE, sh: SH_2};
    return r;
  endfunction

  function automatic instr_t i_ld(rsel_t d, src_t s);
    instr_t r;
    r = '{op: OP_LD, dst: d, s1: R0, s2: R0, src: s, sh: SH_2};
    return r;
  endfunction

  function automatic instr_t i_op(op_t o, rsel_t d, rsel_t a, rsel_t b);
    instr_t r;
    r = '{op: o, dst: d, s1: a, s2: b, src: SRC_ONE, sh: SH_2};
    return r;
  endfunction

  function automatic instr_t i_shl(rsel_t d, rsel_t a, sh_t s);
    instr_t r;
    r = '{op: OP_SHL, dst: d, s1: a, s2: a, src: SRC_ONE, sh: s};
    return r;
  endfunction

  // slab: 4 s^2 - e^2 n, s = ax+by+cz+d 2^16, n = a^2+b^2+c^2
  function automatic instr_t prog_slab(logic [PC_W-1:0] pc);
    instr_t r;
    case (int'(pc))
      0:  r = i_ld(R0, SRC_A);
      1:  r = i_ld(R1, SRC_X);
      2:  r = i_op(OP_MUL, R2, R0, R1);
      3:  r = i_ld(R3, SRC_B);
      4:  r = i_ld(R1, SRC_Y);
      5:  r = i_op(OP_MUL, R4, R3, R1);
      6:  r = i_op(OP_ADD, R2, R2, R4);
      7:  r = i_ld(R5, SRC_C);
      8:  r = i_ld(R1, SRC_Z);
      9:  r = i_op(OP_MUL, R4, R5, R1);
      10: r = i_op(OP_ADD, R2, R2, R4);
      11: r = i_ld(R1, SRC_D);
      12: r = i_shl(R1, R1, SH_16);
      13: r = i_op(OP_ADD, R2, R2, R1);
      14: r = i_op(OP_MUL, R2, R2, R2);
      15: r = i_shl(R2, R2, SH_2);
      16: r = i_op(OP_MUL, R0, R0, R0);
      17: r = i_op(OP_MUL, R3, R3, R3);
      18: r = i_op(OP_ADD, R0, R0, R3);
      19: r = i_op(OP_MUL, R5, R5, R5);
      20: r = i_op(OP_ADD, R0, R0, R5);
      21: r = i_ld(R1, SRC_E);
      22: r = i_op(OP_MUL, R1, R1, R1);
      23: r = i_op(OP_MUL, R1, R1, R0);
      24: r = i_op(OP_SUB, R7, R2, R1);
      default: r = i_end();
    endcase
    return r;
  endfunction

  // sphere: (x-a)^2+(y-b)^2+(z-c)^2 - e^2
  function automatic instr_t prog_sphere(logic [PC_W-1:0] pc);
    instr_t r;
    case (int'(pc))
      0:  r = i_ld(R0, SRC_X);
      1:  r = i_ld(R1, SRC_A);
      2:  r = i_op(OP_SUB, R0, R0, R1);
      3:  r = i_op(OP_MUL, R0, R0, R0);
      4:  r = i_ld(R2, SRC_Y);
      5:  r = i_ld(R1, SRC_B);
      6:  r = i_op(OP_SUB, R2, R2, R1);
      7:  r = i_op(OP_MUL, R2, R2, R2);
      8:  r = i_op(OP_ADD, R0, R0, R2);
      9:  r = i_ld(R2, SRC_Z);
      10: r = i_ld(R1, SRC_C);
      11: r = i_op(OP_SUB, R2, R2, R1);
      12: r = i_op(OP_MUL, R2, R2, R2);
      13: r = i_op(OP_ADD, R0, R0, R2);
      14: r = i_ld(R1, SRC_E);
      15: r = i_op(OP_MUL, R1, R1, R1);
      16: r = i_op(OP_SUB, R7, R0, R1);
      default: r = i_end();
    endcase
    return r;
  endfunction

  // vertical cylinder: (x-a)^2+(z-c)^2 - e^2
  function automatic instr_t prog_cyl_v(logic [PC_W-1:0] pc);
    instr_t r;
    case (int'(pc))
      0:  r = i_ld(R0, SRC_X);
      1:  r = i_ld(R1, SRC_A);
      2:  r = i_op(OP_SUB, R0, R0, R1);
      3:  r = i_op(OP_MUL, R0, R0, R0);
      4:  r = i_ld(R2, SRC_Z);
      5:  r = i_ld(R1, SRC_C);
      6:  r = i_op(OP_SUB, R2, R2, R1);
      7:  r = i_op(OP_MUL, R2, R2, R2);
      8:  r = i_op(OP_ADD, R0, R0, R2);
      9:  r = i_ld(R1, SRC_E);
      10: r = i_op(OP_MUL, R1, R1, R1);
      11: r = i_op(OP_SUB, R7, R0, R1);
      default: r = i_end();
    endcase
    return r;
  endfunction

  // horizontal cylinder: d0^2 - e^2 2^32, d0 = x 2^16 - az - c 2^16
  function automatic instr_t prog_cyl_h(logic [PC_W-1:0] pc);
    instr_t r;
    case (int'(pc))
      0:  r = i_ld(R0, SRC_X);
      1:  r = i_shl(R0, R0, SH_16);
      2:  r = i_ld(R1, SRC_A);
      3:  r = i_ld(R2, SRC_Z);
      4:  r = i_op(OP_MUL, R1, R1, R2);
      5:  r = i_op(OP_SUB, R0, R0, R1);
      6:  r = i_ld(R1, SRC_C);
      7:  r = i_shl(R1, R1, SH_16);
      8:  r = i_op(OP_SUB, R0, R0, R1);
      9:  r = i_op(OP_MUL, R0, R0, R0);
      10: r = i_ld(R1, SRC_E);
      11: r = i_op(OP_MUL, R1, R1, R1);
      12: r = i_shl(R1, R1, SH_32);
      13: r = i_op(OP_SUB, R7, R0, R1);
      default: r = i_end();
    endcase
    return r;
  endfunction

  // inclined cylinder:
  // (d0^2+d1^2) n + d2^2 2^32 - e^2 n 2^32, n = a^2+b^2+2^32
  function automatic instr_t prog_cyl(logic [PC_W-1:0] pc);
    instr_t r;
    case (int'(pc))
      0:  r = i_ld(R0, SRC_X);
      1:  r = i_shl(R0, R0, SH_16);
      2:  r = i_ld(R1, SRC_A);
      3:  r = i_ld(R2, SRC_Z);
      4:  r = i_op(OP_MUL, R1, R1, R2);
      5:  r = i_op(OP_SUB, R0, R0, R1);
      6:  r = i_ld(R1, SRC_C);
      7:  r = i_shl(R1, R1, SH_16);
      8:  r = i_op(OP_SUB, R0, R0, R1);
      9:  r = i_ld(R3, SRC_Y);
      10: r = i_shl(R3, R3, SH_16);
      11: r = i_ld(R1, SRC_B);
      12: r = i_op(OP_MUL, R1, R1, R2);
      13: r = i_op(OP_SUB, R3, R3, R1);
      14: r = i_ld(R1, SRC_D);
      15: r = i_shl(R1, R1, SH_16);
      16: r = i_op(OP_SUB, R3, R3, R1);
      17: r = i_op(OP_MUL, R0, R0, R0);
      18: r = i_op(OP_MUL, R3, R3, R3);
      19: r = i_op(OP_ADD, R0, R0, R3);
      20: r = i_ld(R1, SRC_A);
      21: r = i_op(OP_MUL, R1, R1, R1);
      22: r = i_ld(R3, SRC_B);
      23: r = i_op(OP_MUL, R3, R3, R3);
      24: r = i_op(OP_ADD, R1, R1, R3);
      25: r = i_ld(R3, SRC_ONE);
      26: r = i_shl(R3, R3, SH_32);
      27: r = i_op(OP_ADD, R1, R1, R3);
      28: r = i_op(OP_MUL, R0, R0, R1);
      29: r = i_ld(R2, SRC_X);
      30: r = i_ld(R3, SRC_C);
      31: r = i_op(OP_SUB, R2, R2, R3);
      32: r = i_ld(R3, SRC_B);
      33: r = i_op(OP_MUL, R2, R2, R3);
      34: r = i_ld(R3, SRC_Y);
      35: r = i_ld(R4, SRC_D);
      36: r = i_op(OP_SUB, R3, R3, R4);
      37: r = i_ld(R4, SRC_A);
      38: r = i_op(OP_MUL, R3, R3, R4);
      39: r = i_op(OP_SUB, R2, R2, R3);
      40: r = i_op(OP_MUL, R2, R2, R2);
      41: r = i_shl(R2, R2, SH_32);
      42: r = i_op(OP_ADD, R0, R0, R2);
      43: r = i_ld(R3, SRC_E);
      44: r = i_op(OP_MUL, R3, R3, R3);
      45: r = i_op(OP_MUL, R3, R3, R1);
      46: r = i_shl(R3, R3, SH_32);
      47: r = i_op(OP_SUB, R7, R0, R3);
      default: r = i_end();
    endcase
    return r;
  endfunction

  // half-spaces: common products ax, by, cz, d 2^16, then a signed sum
  localparam int HALF_PRE = 11;

  function automatic instr_t prog_half(logic [3:0] kind, logic [PC_W-1:0] pc);
    instr_t r;
    int     k;
    k = int'(pc) - HALF_PRE;
    case (int'(pc))
      0:  r = i_ld(R0, SRC_A);
      1:  r = i_ld(R1, SRC_X);
      2:  r = i_op(OP_MUL, R0, R0, R1);
      3:  r = i_ld(R2, SRC_B);
      4:  r = i_ld(R1, SRC_Y);
      5:  r = i_op(OP_MUL, R2, R2, R1);
      6:  r = i_ld(R3, SRC_C);
      7:  r = i_ld(R1, SRC_Z);
      8:  r = i_op(OP_MUL, R3, R3, R1);
      9:  r = i_ld(R4, SRC_D);
      10: r = i_shl(R4, R4, SH_16);
      default: begin
        r = i_end();
        case (kind)
          KIND_LOWER: begin
            if (k == 0) r = i_op(OP_ADD, R7, R0, R3);
            if (k == 1) r = i_op(OP_ADD, R7, R7, R4);
            if (k == 2) r = i_op(OP_SUB, R7, R7, R2);
          end
          KIND_LEFT: begin
            if (k == 0) r = i_op(OP_ADD, R7, R2, R3);
            if (k == 1) r = i_op(OP_ADD, R7, R7, R4);
            if (k == 2) r = i_op(OP_SUB, R7, R7, R0);
          end
          KIND_BACK: begin
            if (k == 0) r = i_op(OP_ADD, R7, R0, R2);
            if (k == 1) r = i_op(OP_ADD, R7, R7, R4);
            if (k == 2) r = i_op(OP_SUB, R7, R7, R3);
          end
          default: begin
            if (k == 0) r = i_op(OP_ADD, R7, R0, R2);
            if (k == 1) r = i_op(OP_ADD, R7, R7, R3);
            if (k == 2) r = i_op(OP_ADD, R7, R7, R4);
          end
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic instr_t prog_fetch(logic [3:0] kind, logic [PC_W-1:0] pc);
    instr_t r;
    case (kind)
      KIND_SLAB:   r = prog_slab(pc);
      KIND_SPHERE: r = prog_sphere(pc);
      KIND_CYL:    r = prog_cyl(pc);
      KIND_CYL_H:  r = prog_cyl_h(pc);
      KIND_CYL_V:  r = prog_cyl_v(pc);
      default:     r = prog_half(kind, pc);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/prc_dp.sv
// Datapath: item latch, region table, wide register file, limb multiplier.
// Depends on prc_pkg.
`default_nettype none

module prc_dp import prc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cmd_t     cmd,
  input  prc_req_t req,
  output status_t  status
);

  prc_req_t           item;
  logic [3:0]         kind_tab [NUM_REGIONS];
  logic               nen_tab  [NUM_REGIONS];
  logic               een_tab  [NUM_REGIONS];
  logic signed [31:0] ca [NUM_REGIONS];
  logic signed [31:0] cb [NUM_REGIONS];
  logic signed [31:0] cc [NUM_REGIONS];
  logic signed [31:0] cd [NUM_REGIONS];
  logic signed [31:0] ce [NUM_REGIONS];

  logic [WIDE-1:0]    rf [8];
  logic [WIDE-1:0]    opa, opb;
  logic [WIDE-1:0]    ma, mb, acc;
  logic               msign;
  logic [63:0]        prod;

  logic [REG_W-1:0]   wi;
  logic signed [31:0] opnd;
  logic [WIDE-1:0]    wr_data;
  logic               wr_en;
  logic [31:0]        la, lb;
  logic [8:0]         pp_shift;

  assign wi       = REG_W'(item.region_index);
  assign la       = ma[32*cmd.li +: 32];
  assign lb       = mb[32*cmd.lj +: 32];
  assign pp_shift = {({1'b0, cmd.li} + {1'b0, cmd.lj}), 5'b0};

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) item <= req;
  end

  // region table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NUM_REGIONS; n++) begin
        kind_tab[n] <= '0;
        nen_tab[n]  <= 1'b0;
        een_tab[n]  <= 1'b0;
        ca[n] <= '0;
        cb[n] <= '0;
        cc[n] <= '0;
        cd[n] <= '0;
        ce[n] <= '0;
      end
    end else if (cmd.op == DP_WRITE && int'(item.region_index) < NUM_REGIONS) begin
      case (item.word_select)
        WSEL_KIND: kind_tab[wi] <= item.word_value[3:0];
        WSEL_NEN:  nen_tab[wi]  <= item.word_value[0];
        WSEL_EEN:  een_tab[wi]  <= item.word_value[0];
        WSEL_A:    ca[wi] <= item.word_value;
        WSEL_B:    cb[wi] <= item.word_value;
        WSEL_C:    cc[wi] <= item.word_value;
        WSEL_D:    cd[wi] <= item.word_value;
        default:   ce[wi] <= item.word_value;
      endcase
    end
  end

  always_comb begin
    case (cmd.src)
      SRC_X:   opnd = item.point_x;
      SRC_Y:   opnd = item.point_y;
      SRC_Z:   opnd = item.point_z;
      SRC_A:   opnd = ca[cmd.region];
      SRC_B:   opnd = cb[cmd.region];
      SRC_C:   opnd = cc[cmd.region];
      SRC_D:   opnd = cd[cmd.region];
      SRC_E:   opnd = ce[cmd.region];
      default: opnd = 32'sd1;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_data = '0;
    case (cmd.op)
      DP_LOAD: wr_data = {{(WIDE-32){opnd[31]}}, opnd};
      DP_ADD:  wr_data = opa + opb;
      DP_SUB:  wr_data = opa - opb;
      DP_SHL: begin
        case (cmd.sh)
          SH_2:    wr_data = opa << 2;
          SH_16:   wr_data = opa << 16;
          default: wr_data = opa << 32;
        endcase
      end
      DP_MFIN: wr_data = msign ? -acc : acc;
      default: wr_en = 1'b0;
    endcase
  end

  // register file, one write and two registered reads
  always_ff @(posedge clk) begin
    if (cmd.op == DP_READ) begin
      opa <= rf[cmd.s1];
      opb <= rf[cmd.s2];
    end
    if (wr_en) rf[cmd.dst] <= wr_data;
  end

  // sign-magnitude multiply: one 32x32 limb product is formed (DP_MPP), then shifted and accumulated (DP_MACC)
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_MABS: begin
        ma    <= opa[WIDE-1] ? -opa : opa;
        mb    <= opb[WIDE-1] ? -opb : opb;
        msign <= opa[WIDE-1] ^ opb[WIDE-1];
        acc   <= '0;
      end
      DP_MPP:  prod <= la * lb;
      DP_MACC: acc  <= acc + (WIDE'(prod) << pp_shift);
      default: ;
    endcase
  end

  always_comb begin
    status.na_last = '0;
    status.nb_last = '0;
    for (int l = 0; l < LIMBS; l++) begin
      if (ma[32*l +: 32] != '0) status.na_last = LIMB_W'(l);
      if (mb[32*l +: 32] != '0) status.nb_last = LIMB_W'(l);
    end
    status.en     = item.point_class ? een_tab[cmd.region] : nen_tab[cmd.region];
    status.kind   = kind_tab[cmd.region];
    status.t_neg  = opa[WIDE-1];
    status.t_zero = (opa == '0);
    status.a_neg  = ca[cmd.region][31];
    status.a_zero = (ca[cmd.region] == '0);
    status.b_neg  = cb[cmd.region][31];
    status.b_zero = (cb[cmd.region] == '0);
    status.c_neg  = cc[cmd.region][31];
    status.c_zero = (cc[cmd.region] == '0);
  end

endmodule

`default_nettype wire

FILE: src/prc_ctrl.sv
// Controller: handshakes, region walk, microcode sequencing, result register.
// Depends on prc_pkg.
`default_nettype none

module prc_ctrl import prc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  logic     req_func,
  input  status_t  status,
  output cmd_t     cmd,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output prc_rsp_t rsp
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_WRITE  = 9'b000000010,
    S_REGION = 9'b000000100,
    S_FETCH  = 9'b000001000,
    S_EXEC   = 9'b000010000,
    S_MPP    = 9'b000100000,
    S_MACC   = 9'b001000000,
    S_MFIN   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t             state;
  logic [REG_W-1:0]   r;
  logic [PC_W-1:0]    pc;
  logic [LIMB_W-1:0]  li, lj;
  logic [WHICH_W-1:0] which;
  logic               bad;

  instr_t instr;
  logic   accept, r_last, le, hit;

  // bound test with divisor sign: positive keeps, negative flips,
  // zero keeps only a strictly negative form
  function automatic logic half_ok(logic dn, logic dz, logic tn, logic tz);
    logic ok;
    if (dz)      ok = tn;
    else if (dn) ok = !tn;
    else         ok = tn || tz;
    return ok;
  endfunction

  assign instr     = prog_fetch(status.kind, pc);
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign r_last    = (r == REG_W'(NUM_REGIONS - 1));
  assign le        = status.t_neg || status.t_zero;

  always_comb begin
    case (status.kind)
      KIND_SLAB:
        hit = le && !(status.a_zero && status.b_zero && status.c_zero);
      KIND_SPHERE, KIND_CYL, KIND_CYL_H, KIND_CYL_V: hit = le;
      KIND_UPPER, KIND_LOWER:
        hit = half_ok(status.b_neg, status.b_zero, status.t_neg, status.t_zero);
      KIND_RIGHT, KIND_LEFT:
        hit = half_ok(status.a_neg, status.a_zero, status.t_neg, status.t_zero);
      KIND_FRONT, KIND_BACK:
        hit = half_ok(status.c_neg, status.c_zero, status.t_neg, status.t_zero);
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    cmd.op     = DP_NOP;
    cmd.region = r;
    cmd.dst    = instr.dst;
    cmd.s1     = instr.s1;
    cmd.s2     = instr.s2;
    cmd.src    = instr.src;
    cmd.sh     = instr.sh;
    cmd.li     = li;
    cmd.lj     = lj;
    case (state)
      S_IDLE:  if (accept) cmd.op = DP_LATCH;
      S_WRITE: cmd.op = DP_WRITE;
      S_FETCH: cmd.op = DP_READ;
      S_EXEC: begin
        case (instr.op)
          OP_LD:   cmd.op = DP_LOAD;
          OP_ADD:  cmd.op = DP_ADD;
          OP_SUB:  cmd.op = DP_SUB;
          OP_SHL:  cmd.op = DP_SHL;
          OP_MUL:  cmd.op = DP_MABS;
          default: cmd.op = DP_NOP;
        endcase
      end
      S_MPP:   cmd.op = DP_MPP;
      S_MACC:  cmd.op = DP_MACC;
      S_MFIN:  cmd.op = DP_MFIN;
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      r         <= '0;
      pc        <= '0;
      li        <= '0;
      lj        <= '0;
      which     <= '0;
      bad       <= 1'b0;
    end else begin
      // the finish state reloads the slot itself
      if (rsp_valid && !rsp_stall && state != S_FINISH) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            which <= '0;
            bad   <= 1'b0;
            r     <= '0;
            state <= (req_func == FUNC_WRITE) ? S_WRITE : S_REGION;
          end
        end
        S_WRITE: state <= S_FINISH;
        S_REGION: begin
          if (status.en && status.kind <= KIND_LAST) begin
            pc    <= '0;
            state <= S_FETCH;
          end else begin
            if (status.en) bad <= 1'b1;
            if (r_last) state <= S_FINISH;
            else        r     <= r + REG_W'(1);
          end
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC: begin
          case (instr.op)
            OP_END: begin
              if (hit) which <= WHICH_W'(r) + WHICH_W'(1);
              if (r_last) begin
                state <= S_FINISH;
              end else begin
                r     <= r + REG_W'(1);
                state <= S_REGION;
              end
            end
            OP_MUL: begin
              li    <= '0;
              lj    <= '0;
              state <= S_MPP;
            end
            default: begin
              pc    <= pc + PC_W'(1);
              state <= S_FETCH;
            end
          endcase
        end
        S_MPP: state <= S_MACC;
        S_MACC: begin
          state <= S_MPP;
          if (lj == status.nb_last) begin
            lj <= '0;
            if (li == status.na_last) state <= S_MFIN;
            else                      li    <= li + LIMB_W'(1);
          end else begin
            lj <= lj + LIMB_W'(1);
          end
        end
        S_MFIN: begin
          pc    <= pc + PC_W'(1);
          state <= S_FETCH;
        end
        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.which_region <= which;
            rsp.bad_kind     <= bad;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/point_region_classifier_top.sv
// Top level of the point region classifier: controller plus datapath.
// Depends on prc_pkg, prc_ctrl, prc_dp.
//
// Usage:
//  - req channel (req_valid/req_stall/req) carries one item per handshake.
//    func = write stores one word (kind, node enable, element enable or a
//    coefficient a..e) of one table entry; func = query tests a point.
//  - rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one result per
//    item: which_region = last matching enabled region + 1 (0 for none or a
//    write), bad_kind = an enabled region held a kind code above ten.
//  - One item at a time. A query walks all NUM_REGIONS regions and, for
//    every enabled region with a legal kind, runs its microcode; each
//    multiply step loops over Na*Nb limb products (Na, Nb = 32-bit limbs
//    in use of each operand). The single shared 32x32 multiplier and the
//    register file's one read slot set the rate.
//  - The result sits in an output register; a new item is taken once the
//    result is loaded there, even while the receiver stalls. A stalled
//    result holds until taken; the next result then waits for the slot.
//  - Synchronous reset clears the table to zero (kind slab, disabled) and
//    empties the output register.
`default_nettype none

module point_region_classifier_top import prc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  prc_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output prc_rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  // sequencer: region walk, microcode, result slot
  prc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_func  (req.func),
    .status    (status),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // table, wide registers and limb multiplier
  prc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .status (status)
  );

  // once an item is taken the block is busy for at least the next cycle
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall
  ) else $error("block accepted back-to-back items");

  // a new result only appears after work was in progress
  a_result_from_work: assert property (
    @(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall)
  ) else $error("result raised without an item in flight");

  // a fresh write result never shows bad_kind set with which_region zero
  a_write_clean: assert property (
    @(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.func == FUNC_WRITE) |=> ##2
      (!rsp_valid || rsp.which_region != '0 || !rsp.bad_kind ||
       $past(rsp_valid, 1))
  ) else $error("write item produced a flagged result");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for point_region_classifier_top: writes table words,
// queries points and checks every result against an exact region predictor.
// Depends on prc_pkg and the RTL of the block only.
`default_nettype none

module testbench;
  import prc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  // word_select code for coefficient e (the package names only up to d)
  localparam logic [2:0] SEL_COEF_E = 3'd7;
  // Cycles with no accepted item or taken result before the run is declared hung.
  // A query walks all eight regions, running microcode for each enabled one.
  localparam int HANG_LIMIT = 50000;
  localparam int RANDOM_ITEMS = 1500;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  prc_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  prc_rsp_t rsp;

  point_region_classifier_top i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the region table
  logic [3:0]         tbl_kind [NUM_REGIONS];
  logic               tbl_nen  [NUM_REGIONS];
  logic               tbl_een  [NUM_REGIONS];
  logic signed [31:0] tbl_a [NUM_REGIONS];
  logic signed [31:0] tbl_b [NUM_REGIONS];
  logic signed [31:0] tbl_c [NUM_REGIONS];
  logic signed [31:0] tbl_d [NUM_REGIONS];
  logic signed [31:0] tbl_e [NUM_REGIONS];

  prc_req_t pending_items[$];
  prc_rsp_t expected_rsp[$];
  int       errors = 0;
  int       idle_cycles = 0;

  // Half-space decision: divisor sign picks the comparison,
  // a zero divisor keeps only a strictly negative form.
  function automatic bit half_hit(wide_t s, logic signed [31:0] dv);
    if (dv > 0) return s <= 0;
    if (dv < 0) return s >= 0;
    return s < 0;
  endfunction

  // Exact containment test, all divisions multiplied out.
  function automatic bit region_hit(int r, wide_t x, wide_t y, wide_t z);
    wide_t a, b, c, d, e, ax, by, cz, dd, e2, s, n, d0, d1, d2, u;
    a = tbl_a[r]; b = tbl_b[r]; c = tbl_c[r]; d = tbl_d[r]; e = tbl_e[r];
    u  = wide_t'(1) <<< 32;
    ax = a * x; by = b * y; cz = c * z;
    dd = d <<< 16;
    e2 = e * e;
    case (tbl_kind[r])
      KIND_SLAB: begin
        s = ax + by + cz + dd;
        n = a * a + b * b + c * c;
        if (n == 0) return 1'b0;
        return 4 * s * s <= e2 * n;
      end
      KIND_SPHERE: return (x - a) * (x - a) + (y - b) * (y - b) + (z - c) * (z - c) <= e2;
      KIND_CYL: begin
        d0 = (x <<< 16) - a * z - (c <<< 16);
        d1 = (y <<< 16) - b * z - dd;
        d2 = b * (x - c) - a * (y - d);
        n  = a * a + b * b + u;
        return (d0 * d0 + d1 * d1) * n + d2 * d2 * u <= e2 * n * u;
      end
      KIND_CYL_H: begin
        d0 = (x <<< 16) - a * z - (c <<< 16);
        return d0 * d0 <= e2 * u;
      end
      KIND_CYL_V: return (x - a) * (x - a) + (z - c) * (z - c) <= e2;
      KIND_UPPER: return half_hit(ax + by + cz + dd, tbl_b[r]);
      KIND_LOWER: return half_hit(ax + cz + dd - by, tbl_b[r]);
      KIND_RIGHT: return half_hit(ax + by + cz + dd, tbl_a[r]);
      KIND_LEFT:  return half_hit(by + cz + dd - ax, tbl_a[r]);
      KIND_FRONT: return half_hit(ax + by + cz + dd, tbl_c[r]);
      KIND_BACK:  return half_hit(ax + by + dd - cz, tbl_c[r]);
      default:    return 1'b0;
    endcase
  endfunction

  // Applies a write to the shadow table or classifies a point.
  function automatic prc_rsp_t classify_item(prc_req_t it);
    prc_rsp_t o;
    wide_t    x, y, z;
    int       r;
    o = '0;
    if (it.func == FUNC_WRITE) begin
      r = it.region_index;
      case (it.word_select)
        WSEL_KIND: tbl_kind[r] = it.word_value[3:0];
        WSEL_NEN:  tbl_nen[r]  = it.word_value[0];
        WSEL_EEN:  tbl_een[r]  = it.word_value[0];
        WSEL_A:    tbl_a[r]    = it.word_value;
        WSEL_B:    tbl_b[r]    = it.word_value;
        WSEL_C:    tbl_c[r]    = it.word_value;
        WSEL_D:    tbl_d[r]    = it.word_value;
        default:   tbl_e[r]    = it.word_value;
      endcase
    end else begin
      x = it.point_x; y = it.point_y; z = it.point_z;
      for (r = 0; r < NUM_REGIONS; r++) begin
        if (it.point_class ? tbl_een[r] : tbl_nen[r]) begin
          if (tbl_kind[r] > KIND_LAST) o.bad_kind = 1'b1;
          else if (region_hit(r, x, y, z)) o.which_region = WHICH_W'(r + 1);
        end
      end
    end
    return o;
  endfunction

  // Mostly small Q16.16 values so shapes and points overlap, some full range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'd0;
      2: return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
      default: return 32'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic prc_req_t noise_item();
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(prc_req_t)-1:0];
  endfunction

  task automatic add_write(int r, logic [2:0] sel, logic [31:0] v);
    prc_req_t it;
    it = noise_item();
    it.func = FUNC_WRITE;
    it.region_index = 3'(r);
    it.word_select = sel;
    it.word_value = v;
    pending_items.push_back(it);
  endtask

  task automatic add_query(logic cls, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    prc_req_t it;
    it = noise_item();
    it.func = FUNC_QUERY;
    it.point_class = cls;
    it.point_x = x; it.point_y = y; it.point_z = z;
    pending_items.push_back(it);
  endtask

  // ---------------- stimulus ----------------
  initial begin
    int k;
    logic [31:0] v;
    for (k = 0; k < NUM_REGIONS; k++) begin
      tbl_kind[k] = '0; tbl_nen[k] = 1'b0; tbl_een[k] = 1'b0;
      tbl_a[k] = '0; tbl_b[k] = '0; tbl_c[k] = '0; tbl_d[k] = '0; tbl_e[k] = '0;
    end

    // Directed: empty table, degenerate slab, sphere, unknown kind,
    // half-space with zero and negative divisor, extreme points.
    add_query(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    add_write(0, WSEL_NEN, 32'hffff_ffff);
    add_query(1'b0, 32'h0, 32'h0, 32'h0);               // slab, a=b=c=0
    add_write(0, WSEL_KIND, {28'hfff_fff0, KIND_SPHERE});
    add_write(0, SEL_COEF_E, 32'h0001_0000);
    add_query(1'b0, 32'h0, 32'h0001_0000, 32'h0);        // on the surface
    add_write(7, WSEL_KIND, 32'd15);
    add_write(7, WSEL_EEN, 32'h1);
    add_query(1'b1, 32'h0, 32'h0, 32'h0);                // unknown kind
    add_write(3, WSEL_KIND, 32'(KIND_UPPER));
    add_write(3, WSEL_NEN, 32'h1);
    add_query(1'b0, 32'h1234_5678, 32'h0, 32'h0);        // zero divisor, zero form
    add_write(3, WSEL_D, 32'hffff_ffff);
    add_query(1'b0, 32'h0, 32'h0, 32'h0);                // zero divisor, negative form
    add_write(3, WSEL_B, 32'h8000_0000);
    add_query(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_write(3, WSEL_A, 32'h7fff_ffff);
    add_write(3, WSEL_C, 32'h8000_0000);
    add_query(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    add_write(0, WSEL_KIND, 32'(KIND_CYL));
    add_query(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);

    // Random: mostly table writes with meaningful content, queries around them.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        pending_items.push_back(noise_item());
      end else if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            v = $urandom;
            v[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                                  : 4'($urandom_range(0, 10));
            add_write($urandom_range(0, 7), WSEL_KIND, v);
          end
          2: add_write($urandom_range(0, 7), WSEL_NEN, $urandom);
          3: add_write($urandom_range(0, 7), WSEL_EEN, $urandom);
          default: add_write($urandom_range(0, 7), 3'($urandom_range(3, 7)), pick_value());
        endcase
      end else begin
        add_query(1'($urandom_range(0, 1)), pick_value(), pick_value(), pick_value());
      end
    end

    wait (pending_items.size() == 0 && !req_valid && expected_rsp.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------- driver: bursts with random gaps ----------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) expected_rsp.push_back(classify_item(req));
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          req <= pending_items.pop_front();
          req_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver stall pattern and checker ----------------
  int stall_left = 0;

  always @(posedge clk) begin
    prc_rsp_t exp_r;
    if (stall_left == 0) begin
      // pick stalled or free stretches at random; free ones can be long
      if ($urandom_range(0, 2) == 0) begin
        rsp_stall <= 1'b1;
        stall_left <= $urandom_range(1, 15);
      end else begin
        rsp_stall <= 1'b0;
        stall_left <= $urandom_range(1, 60);
      end
    end else begin
      stall_left <= stall_left - 1;
    end

    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d/%0b",
                 $time, rsp.which_region, rsp.bad_kind);
      end else begin
        exp_r = expected_rsp.pop_front();
        if (rsp.which_region !== exp_r.which_region) begin
          errors++;
          $display("%0t: which_region expected %0d actual %0d",
                   $time, exp_r.which_region, rsp.which_region);
        end
        if (rsp.bad_kind !== exp_r.bad_kind) begin
          errors++;
          $display("%0t: bad_kind expected %0b actual %0b",
                   $time, exp_r.bad_kind, rsp.bad_kind);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

endmodule

`default_nettype wire
